### sv/smpr_pkg.sv
// ----------------------------------------------------------------------------
// smpr_pkg
// Shared widths, register codes, CORDIC tables and helpers for the sine
// modulated pixel remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package smpr_pkg;

	// coordinate and sample widths actually used
	localparam int COORD_BITS = 16;
	localparam int PIXEL_BITS = 16;

	// port widths of the fields
	localparam int COL_W   = 16;
	localparam int ROW_W   = 16;
	localparam int PIXEL_W = 16;
	localparam int OUT_W   = 34;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_PHASE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PHASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_AMP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_AMP   = 3'd5;

	localparam int ANG_W = 32;
	localparam int AMP_W = 16;
	localparam int TRIG_W = 16;

	typedef struct packed {
		logic [ANG_W-1:0]        freq_x;
		logic [ANG_W-1:0]        freq_y;
		logic [ANG_W-1:0]        scale_phase;
		logic [ANG_W-1:0]        offset_phase;
		logic signed [AMP_W-1:0] scale_amp;
		logic signed [AMP_W-1:0] offset_amp;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		freq_x:       32'd68356526,
		freq_y:       32'd68356526,
		scale_phase:  32'd0,
		offset_phase: 32'd0,
		scale_amp:    16'sd512,
		offset_amp:   16'sd512
	};

	// cordic
	localparam int CORDIC_W        = 33;
	localparam int CORDIC_ITERS    = 16;
	localparam int ITERS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

	localparam logic signed [CORDIC_W-1:0] CORDIC_ONE = 33'sd652032874;

	localparam logic signed [CORDIC_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331,  33'sd21354465,  33'sd10680350,  33'sd5340245,
		33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
		33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
	};

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic signed [TRIG_W-1:0] Q15_MAX = 16'sd32767;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
	} cordic_t;

	// one rotation-mode micro-rotation
	function automatic cordic_t cordic_iter(cordic_t v, int unsigned i);
		cordic_t                    r;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		dx = v.y >>> i;
		dy = v.x >>> i;
		if (!v.z[CORDIC_W-1]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - ATAN_TURN[i[$clog2(CORDIC_ITERS)-1:0]];
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + ATAN_TURN[i[$clog2(CORDIC_ITERS)-1:0]];
		end
		return r;
	endfunction

	// round to q1.15 and clamp to the symmetric range
	function automatic logic signed [TRIG_W-1:0] to_q15(logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W-1:0] r;
		r = (v + CORDIC_W'(16384)) >>> 15;
		if (r > CORDIC_W'(Q15_MAX))
			return Q15_MAX;
		else if (r < -CORDIC_W'(Q15_MAX))
			return -Q15_MAX;
		else
			return r[TRIG_W-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/smpr_angle.sv
// ----------------------------------------------------------------------------
// smpr_angle
// Angle stages: column and row products, then base angle plus the two phases.
// ----------------------------------------------------------------------------
`default_nettype none

module smpr_angle (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire smpr_pkg::cfg_t                 cfg,
	input  wire logic                           valid_in,
	input  wire logic [smpr_pkg::COL_W-1:0]     col,
	input  wire logic [smpr_pkg::ROW_W-1:0]     row,
	input  wire logic [smpr_pkg::PIXEL_W-1:0]   pixel,
	output logic                                valid_out,
	output logic [smpr_pkg::ANG_W-1:0]          ang_sin,
	output logic [smpr_pkg::ANG_W-1:0]          ang_cos,
	output logic [smpr_pkg::PIXEL_BITS-1:0]     pixel_out
);
	import smpr_pkg::*;

	localparam int PROD_W = ANG_W + COORD_BITS;

	logic [PROD_W-1:0]     mult_x;
	logic [PROD_W-1:0]     mult_y;
	logic [ANG_W-1:0]      base;

	logic                  valid_s1;
	logic [ANG_W-1:0]      prod_x_s1;
	logic [ANG_W-1:0]      prod_y_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;

	logic                  valid_s2;
	logic [ANG_W-1:0]      ang_sin_s2;
	logic [ANG_W-1:0]      ang_cos_s2;
	logic [PIXEL_BITS-1:0] pixel_s2;

	// only the low word of each product matters, the angle wraps per turn
	assign mult_x = cfg.freq_x * col[COORD_BITS-1:0];
	assign mult_y = cfg.freq_y * row[COORD_BITS-1:0];
	assign base   = prod_x_s1 + prod_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1  <= mult_x[ANG_W-1:0];
			prod_y_s1  <= mult_y[ANG_W-1:0];
			pixel_s1   <= pixel[PIXEL_BITS-1:0];
			ang_sin_s2 <= base + cfg.scale_phase;
			ang_cos_s2 <= base + cfg.offset_phase;
			pixel_s2   <= pixel_s1;
		end
	end

	assign valid_out = valid_s2;
	assign ang_sin   = ang_sin_s2;
	assign ang_cos   = ang_cos_s2;
	assign pixel_out = pixel_s2;

endmodule

`default_nettype wire

### sv/smpr_cordic.sv
// ----------------------------------------------------------------------------
// smpr_cordic
// Two-lane pipelined rotation CORDIC: sine of one angle, cosine of another,
// two micro-rotations per stage, then q1.15 rounding and quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module smpr_cordic (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              valid_in,
	input  wire logic [smpr_pkg::ANG_W-1:0]        ang_sin,
	input  wire logic [smpr_pkg::ANG_W-1:0]        ang_cos,
	input  wire logic [smpr_pkg::PIXEL_BITS-1:0]   pixel_in,
	output logic                                   valid_out,
	output logic signed [smpr_pkg::TRIG_W-1:0]     sine,
	output logic signed [smpr_pkg::TRIG_W-1:0]     cosine,
	output logic [smpr_pkg::PIXEL_BITS-1:0]        pixel_out
);
	import smpr_pkg::*;

	cordic_t               init_sin;
	cordic_t               init_cos;

	cordic_t               lane_sin_s [CORDIC_STAGES];
	cordic_t               lane_cos_s [CORDIC_STAGES];
	logic [1:0]            quad_sin_s [CORDIC_STAGES];
	logic [1:0]            quad_cos_s [CORDIC_STAGES];
	logic [PIXEL_BITS-1:0] pixel_st_s [CORDIC_STAGES];
	logic                  valid_st_s [CORDIC_STAGES];

	logic signed [TRIG_W-1:0] sin_lane_s;
	logic signed [TRIG_W-1:0] sin_lane_c;
	logic signed [TRIG_W-1:0] cos_lane_s;
	logic signed [TRIG_W-1:0] cos_lane_c;
	logic signed [TRIG_W-1:0] sine_d;
	logic signed [TRIG_W-1:0] cosine_d;

	logic                     valid_s9;
	logic signed [TRIG_W-1:0] sine_s9;
	logic signed [TRIG_W-1:0] cosine_s9;
	logic [PIXEL_BITS-1:0]    pixel_s9;

	// residual angle below a quarter turn
	assign init_sin = '{x: CORDIC_ONE, y: '0,
		z: {{(CORDIC_W-ANG_W+2){1'b0}}, ang_sin[ANG_W-3:0]}};
	assign init_cos = '{x: CORDIC_ONE, y: '0,
		z: {{(CORDIC_W-ANG_W+2){1'b0}}, ang_cos[ANG_W-3:0]}};

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		cordic_t               sin_in;
		cordic_t               cos_in;
		cordic_t               sin_mid;
		cordic_t               cos_mid;
		logic [1:0]            qs_in;
		logic [1:0]            qc_in;
		logic [PIXEL_BITS-1:0] pix_in;
		logic                  vld_in;

		if (g == 0) begin : g_first
			assign sin_in = init_sin;
			assign cos_in = init_cos;
			assign qs_in  = ang_sin[ANG_W-1:ANG_W-2];
			assign qc_in  = ang_cos[ANG_W-1:ANG_W-2];
			assign pix_in = pixel_in;
			assign vld_in = valid_in;
		end else begin : g_next
			assign sin_in = lane_sin_s[g-1];
			assign cos_in = lane_cos_s[g-1];
			assign qs_in  = quad_sin_s[g-1];
			assign qc_in  = quad_cos_s[g-1];
			assign pix_in = pixel_st_s[g-1];
			assign vld_in = valid_st_s[g-1];
		end

		assign sin_mid = cordic_iter(sin_in, ITERS_PER_STAGE * g);
		assign cos_mid = cordic_iter(cos_in, ITERS_PER_STAGE * g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_st_s[g] <= 1'b0;
			end else if (en) begin
				valid_st_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_sin_s[g] <= cordic_iter(sin_mid, ITERS_PER_STAGE * g + 1);
				lane_cos_s[g] <= cordic_iter(cos_mid, ITERS_PER_STAGE * g + 1);
				quad_sin_s[g] <= qs_in;
				quad_cos_s[g] <= qc_in;
				pixel_st_s[g] <= pix_in;
			end
		end
	end

	assign sin_lane_s = to_q15(lane_sin_s[CORDIC_STAGES-1].y);
	assign sin_lane_c = to_q15(lane_sin_s[CORDIC_STAGES-1].x);
	assign cos_lane_s = to_q15(lane_cos_s[CORDIC_STAGES-1].y);
	assign cos_lane_c = to_q15(lane_cos_s[CORDIC_STAGES-1].x);

	// fold the quarter-turn result back through the quadrant
	always_comb begin
		case (quad_sin_s[CORDIC_STAGES-1])
			QUAD_0:  sine_d = sin_lane_s;
			QUAD_1:  sine_d = sin_lane_c;
			QUAD_2:  sine_d = -sin_lane_s;
			default: sine_d = -sin_lane_c;
		endcase
		case (quad_cos_s[CORDIC_STAGES-1])
			QUAD_0:  cosine_d = cos_lane_c;
			QUAD_1:  cosine_d = -cos_lane_s;
			QUAD_2:  cosine_d = -cos_lane_c;
			default: cosine_d = cos_lane_s;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= valid_st_s[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s9   <= sine_d;
			cosine_s9 <= cosine_d;
			pixel_s9  <= pixel_st_s[CORDIC_STAGES-1];
		end
	end

	assign valid_out = valid_s9;
	assign sine      = sine_s9;
	assign cosine    = cosine_s9;
	assign pixel_out = pixel_s9;

endmodule

`default_nettype wire

### sv/smpr_mix.sv
// ----------------------------------------------------------------------------
// smpr_mix
// Output stages: amplitude products, pixel product, sum, rounding and
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smpr_mix (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire smpr_pkg::cfg_t                    cfg,
	input  wire logic                              valid_in,
	input  wire logic signed [smpr_pkg::TRIG_W-1:0] sine,
	input  wire logic signed [smpr_pkg::TRIG_W-1:0] cosine,
	input  wire logic [smpr_pkg::PIXEL_BITS-1:0]   pixel,
	output logic                                   valid_out,
	output logic signed [smpr_pkg::OUT_W-1:0]      value
);
	import smpr_pkg::*;

	localparam int AP_W   = AMP_W + TRIG_W;
	localparam int TERM_W = AP_W + PIXEL_BITS + 1;
	localparam int SUM_W  = TERM_W + 1;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

	logic signed [AP_W-1:0]   prod_sin;
	logic signed [AP_W-1:0]   prod_cos;
	logic signed [TERM_W-1:0] term;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  rounded;
	logic signed [OUT_W-1:0]  sat;

	logic                     valid_s1;
	logic signed [AP_W-1:0]   prod_sin_s1;
	logic signed [AP_W-1:0]   prod_cos_s1;
	logic [PIXEL_BITS-1:0]    pixel_s1;

	logic                     valid_s2;
	logic signed [TERM_W-1:0] term_s2;
	logic signed [AP_W-1:0]   prod_cos_s2;

	logic                     valid_s3;
	logic signed [OUT_W-1:0]  value_s3;

	assign prod_sin = cfg.scale_amp * sine;
	assign prod_cos = cfg.offset_amp * cosine;
	assign term     = prod_sin_s1 * $signed({1'b0, pixel_s1});

	// 23 fraction bits down to 8, halves round up
	assign sum     = SUM_W'(term_s2) + SUM_W'(prod_cos_s2);
	assign rounded = (sum + SUM_W'(16384)) >>> 15;

	always_comb begin
		if (rounded > SAT_HI)
			sat = OUT_MAX;
		else if (rounded < SAT_LO)
			sat = OUT_MIN;
		else
			sat = rounded[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sin_s1 <= prod_sin;
			prod_cos_s1 <= prod_cos;
			pixel_s1    <= pixel;
			term_s2     <= term;
			prod_cos_s2 <= prod_cos_s1;
			value_s3    <= sat;
		end
	end

	assign valid_out = valid_s3;
	assign value     = value_s3;

endmodule

`default_nettype wire

### sv/sine_modulated_pixel_remap_core.sv
// ----------------------------------------------------------------------------
// sine_modulated_pixel_remap_core
// Per-pixel sine gain and cosine offset driven by a linear angle over x and y.
// ----------------------------------------------------------------------------
// Input beats carry col, row and pixel on in_valid / in_stall; result beats
// carry out_value on out_valid / out_stall. A beat moves on a rising edge
// with valid high and stall low.
// Registers are loaded through cfg_we / cfg_index / cfg_data, one register a
// cycle; the user must load them only while the pipeline is empty, which the
// block itself does not enforce; unknown indexes are ignored. A beat passes
// through two angle stages, eight CORDIC stages of two micro-rotations each,
// a rounding and quadrant stage, and three product, sum and saturation stages.
// Throughput is one pixel per cycle unless stalled; each stage holds one beat.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_modulated_pixel_remap_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [smpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [smpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [smpr_pkg::COL_W-1:0]        col,
	input  wire logic [smpr_pkg::ROW_W-1:0]        row,
	input  wire logic [smpr_pkg::PIXEL_W-1:0]      pixel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [smpr_pkg::OUT_W-1:0]      out_value
);
	import smpr_pkg::*;

	cfg_t                     cfg_q;
	logic                     en;

	logic                     ang_valid;
	logic [ANG_W-1:0]         ang_sin;
	logic [ANG_W-1:0]         ang_cos;
	logic [PIXEL_BITS-1:0]    ang_pixel;

	logic                     trig_valid;
	logic signed [TRIG_W-1:0] trig_sin;
	logic signed [TRIG_W-1:0] trig_cos;
	logic [PIXEL_BITS-1:0]    trig_pixel;

	// hold everything while a finished beat waits at the output
	assign in_stall = out_valid && out_stall;
	assign en       = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREQ_X:       cfg_q.freq_x       <= cfg_data[ANG_W-1:0];
				REG_FREQ_Y:       cfg_q.freq_y       <= cfg_data[ANG_W-1:0];
				REG_SCALE_PHASE:  cfg_q.scale_phase  <= cfg_data[ANG_W-1:0];
				REG_OFFSET_PHASE: cfg_q.offset_phase <= cfg_data[ANG_W-1:0];
				REG_SCALE_AMP:    cfg_q.scale_amp    <= $signed(cfg_data[AMP_W-1:0]);
				REG_OFFSET_AMP:   cfg_q.offset_amp   <= $signed(cfg_data[AMP_W-1:0]);
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	smpr_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.valid_in  (in_valid),
		.col       (col),
		.row       (row),
		.pixel     (pixel),
		.valid_out (ang_valid),
		.ang_sin   (ang_sin),
		.ang_cos   (ang_cos),
		.pixel_out (ang_pixel)
	);

	smpr_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (ang_valid),
		.ang_sin   (ang_sin),
		.ang_cos   (ang_cos),
		.pixel_in  (ang_pixel),
		.valid_out (trig_valid),
		.sine      (trig_sin),
		.cosine    (trig_cos),
		.pixel_out (trig_pixel)
	);

	smpr_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.valid_in  (trig_valid),
		.sine      (trig_sin),
		.cosine    (trig_cos),
		.pixel     (trig_pixel),
		.valid_out (out_valid),
		.value     (out_value)
	);

endmodule

`default_nettype wire
